### hw/rtl/wrm_pkg.sv
// Shared types and constants of the windowed RMS level meter.
package wrm_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned SUM_W    = 41;
	localparam int unsigned SQ_W     = 31;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;

	localparam int unsigned DIV_STEPS  = SUM_W;
	localparam int unsigned ROOT_STEPS = LEVEL_W;
	localparam int unsigned STEP_W     = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_ROOT,
		ST_PUSH
	} wrm_state_t;

	typedef struct packed {
		logic take;
		logic accum;
		logic div_load;
		logic div_step;
		logic root_step;
		logic out_load;
	} wrm_cmd_t;

	typedef struct packed {
		logic close;
		logic out_free;
	} wrm_sts_t;

endpackage

### hw/rtl/wrm_if.sv
// Request channels of the meter: samples in, levels out.
interface wrm_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [wrm_pkg::SAMPLE_W-1:0] sample;
	logic                                block_end;

	modport source (output valid, output sample, output block_end, input ready);
	modport sink (input valid, input sample, input block_end, output ready);
endinterface

interface wrm_out_if;
	logic                         valid;
	logic                         ready;
	logic [wrm_pkg::LEVEL_W-1:0]  rms_level;
	logic [wrm_pkg::COUNT_W-1:0]  window_count;
	logic                         block_done;

	modport source (output valid, output rms_level, output window_count, output block_done,
		input ready);
	modport sink (input valid, input rms_level, input window_count, input block_done,
		output ready);
endinterface

### hw/rtl/wrm_ctrl.sv
// Sequencer of the meter: accept, accumulate, divide, root, push.
module wrm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wrm_pkg::wrm_sts_t sts,
	output wrm_pkg::wrm_cmd_t cmd
);

	wrm_pkg::wrm_state_t           state_q, state_d;
	logic [wrm_pkg::STEP_W-1:0]    step_q;
	logic                          div_last, root_last;

	assign div_last  = (step_q == wrm_pkg::STEP_W'(wrm_pkg::DIV_STEPS - 1));
	assign root_last = (step_q == wrm_pkg::STEP_W'(wrm_pkg::ROOT_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			wrm_pkg::ST_IDLE: begin
				if (in_valid) state_d = wrm_pkg::ST_ACC;
			end
			wrm_pkg::ST_ACC: begin
				state_d = sts.close ? wrm_pkg::ST_DIV : wrm_pkg::ST_IDLE;
			end
			wrm_pkg::ST_DIV: begin
				if (div_last) state_d = wrm_pkg::ST_ROOT;
			end
			wrm_pkg::ST_ROOT: begin
				if (root_last) state_d = wrm_pkg::ST_PUSH;
			end
			wrm_pkg::ST_PUSH: begin
				if (sts.out_free) state_d = wrm_pkg::ST_IDLE;
			end
			default: state_d = wrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wrm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			wrm_pkg::ST_ACC: begin
				cmd.accum    = 1'b1;
				cmd.div_load = sts.close;
			end
			wrm_pkg::ST_DIV:  cmd.div_step  = 1'b1;
			wrm_pkg::ST_ROOT: cmd.root_step = 1'b1;
			wrm_pkg::ST_PUSH: cmd.out_load  = sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrm_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
		end
	end

endmodule

### hw/rtl/wrm_datapath.sv
// Datapath of the meter: square, accumulate, restoring divide, digit root, output register.
module wrm_datapath #(
	parameter int unsigned WINDOW = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [wrm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                block_end,
	input  wrm_pkg::wrm_cmd_t                   cmd,
	output wrm_pkg::wrm_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wrm_pkg::LEVEL_W-1:0]         rms_level,
	output logic [wrm_pkg::COUNT_W-1:0]         window_count,
	output logic                                block_done
);

	localparam int unsigned EFF_INT = (WINDOW < 1) ? 1 :
		((WINDOW > wrm_pkg::COUNT_MAX) ? wrm_pkg::COUNT_MAX : WINDOW);
	localparam logic [wrm_pkg::COUNT_W-1:0] EFF_WIN = wrm_pkg::COUNT_W'(EFF_INT);

	logic [wrm_pkg::SAMPLE_W-1:0]   samp_u, mag;
	logic [2*wrm_pkg::SAMPLE_W-1:0] sq_full;
	logic [wrm_pkg::SQ_W-1:0]       sq_s1;
	logic                           last_s1;

	logic [wrm_pkg::SUM_W-1:0]      sum_q, sum_next;
	logic [wrm_pkg::COUNT_W-1:0]    cnt_q, cnt_next;

	logic [wrm_pkg::SUM_W-1:0]      dvd_q;
	logic [wrm_pkg::COUNT_W-1:0]    rem_q, dvs_q;
	logic [wrm_pkg::COUNT_W:0]      div_r, div_diff;
	logic                           div_ge;

	logic [wrm_pkg::LEVEL_W:0]      rt_rem_q;
	logic [wrm_pkg::LEVEL_W-1:0]    rt_q;
	logic [wrm_pkg::LEVEL_W+2:0]    rt_r, rt_t, rt_diff;
	logic                           rt_ge;

	logic [wrm_pkg::COUNT_W-1:0]    wcnt_q;
	logic                           done_q;

	logic                           out_valid_q;
	logic [wrm_pkg::LEVEL_W-1:0]    level_q;
	logic [wrm_pkg::COUNT_W-1:0]    ocnt_q;
	logic                           odone_q;

	assign samp_u  = sample;
	assign mag     = sample[wrm_pkg::SAMPLE_W-1] ? (~samp_u + 1'b1) : samp_u;
	assign sq_full = mag * mag;

	assign sum_next = sum_q + wrm_pkg::SUM_W'(sq_s1);
	assign cnt_next = cnt_q + 1'b1;

	assign sts.close    = last_s1 || (cnt_next >= EFF_WIN);
	assign sts.out_free = !out_valid_q || out_ready;

	assign div_r    = {rem_q, dvd_q[wrm_pkg::SUM_W-1]};
	assign div_diff = div_r - {1'b0, dvs_q};
	assign div_ge   = (div_r >= {1'b0, dvs_q});

	assign rt_r    = {rt_rem_q, dvd_q[2*wrm_pkg::LEVEL_W-1 -: 2]};
	assign rt_t    = {1'b0, rt_q, 2'b01};
	assign rt_diff = rt_r - rt_t;
	assign rt_ge   = (rt_r >= rt_t);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sq_s1   <= wrm_pkg::SQ_W'(sq_full);
			last_s1 <= block_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accum) begin
			if (cmd.div_load) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q    <= sum_next;
			dvs_q    <= cnt_next;
			rem_q    <= '0;
			rt_rem_q <= '0;
			rt_q     <= '0;
			wcnt_q   <= cnt_next;
			done_q   <= last_s1;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[wrm_pkg::COUNT_W-1:0] : div_r[wrm_pkg::COUNT_W-1:0];
			dvd_q <= {dvd_q[wrm_pkg::SUM_W-2:0], div_ge};
		end else if (cmd.root_step) begin
			rt_rem_q <= rt_ge ? rt_diff[wrm_pkg::LEVEL_W:0] : rt_r[wrm_pkg::LEVEL_W:0];
			rt_q     <= {rt_q[wrm_pkg::LEVEL_W-2:0], rt_ge};
			dvd_q    <= {dvd_q[wrm_pkg::SUM_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q <= rt_q;
			ocnt_q  <= wcnt_q;
			odone_q <= done_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign rms_level    = level_q;
	assign window_count = ocnt_q;
	assign block_done   = odone_q;

`ifndef SYNTHESIS
	a_cnt_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < EFF_WIN)
		else $error("open window count reached the window length");
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (dvs_q != '0) && (rem_q < dvs_q))
		else $error("divider remainder out of range");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (rt_q <= wrm_pkg::LEVEL_W'(32768)))
		else $error("level above full scale");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (wcnt_q != '0) && (wcnt_q <= EFF_WIN))
		else $error("window count out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("result register overwritten");
`endif

endmodule

### hw/rtl/windowed_rms_meter_top.sv
// Top level of the windowed RMS level meter.
// Usage:
//  samples: one request per Q1.15 audio sample, with block_end on the last sample
//  of a block. levels: one request per closed window, carrying rms_level
//  (floor root of the floor mean square), window_count and block_done.
//  A window closes after WINDOW samples (held to 1..2047) or on block_end.
// Sequence:
//  A sample that leaves the window open is squared on accept and accumulated
//  on the next cycle.
//  A closing sample passes square and accumulate, the bit-serial restoring
//  divider, the digit-by-digit square root and the load of the output
//  register before the next sample is accepted.
//  The result shows on levels the cycle after that load.
// Stall:
//  The output register holds a result until taken; samples keep flowing
//  meanwhile. Only a second result waits, in the push step, until the first
//  one is taken.
// Reset:
//  arst_n clears the running sum, the sample count, the sequencer and the
//  output valid; no result is pending after reset.
module windowed_rms_meter_top #(
	parameter int unsigned WINDOW = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	wrm_in_if.sink          samples,
	wrm_out_if.source       levels
);

	wrm_pkg::wrm_cmd_t cmd;
	wrm_pkg::wrm_sts_t sts;

	wrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrm_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (samples.sample),
		.block_end    (samples.block_end),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (levels.valid),
		.out_ready    (levels.ready),
		.rms_level    (levels.rms_level),
		.window_count (levels.window_count),
		.block_done   (levels.block_done)
	);

endmodule

### bench/windowed_rms_meter_top_tb.sv
// Self-checking testbench of the RMS level meter: directed and random samples against a predictor.
`timescale 1ns / 100ps

module windowed_rms_meter_top_tb;

	localparam int unsigned WIN        = 1024;
	localparam int          MAX_WAIT   = 11;
	localparam int          RAND_ITEMS = 720;
	localparam int          IDLE_LIMIT = 4000;
	localparam int          SETTLE     = 80;

	localparam logic signed [wrm_pkg::SAMPLE_W-1:0] MOST_NEG = 16'sh8000;
	localparam logic signed [wrm_pkg::SAMPLE_W-1:0] MOST_POS = 16'sh7FFF;

	typedef struct {
		logic [wrm_pkg::LEVEL_W-1:0] rms_level;
		logic [wrm_pkg::COUNT_W-1:0] window_count;
		logic                        block_done;
	} level_rec_t;

	class rms_window_tracker;
		int unsigned                 eff_window;
		logic [wrm_pkg::SUM_W-1:0]   square_sum;
		logic [wrm_pkg::COUNT_W-1:0] sample_count;
		level_rec_t                  levels_due[$];
		int                          faults;
		int                          samples_taken;
		int                          windows_full;
		int                          windows_ended;

		function new(int unsigned win);
			eff_window    = (win < 1) ? 1 :
				((win > wrm_pkg::COUNT_MAX) ? wrm_pkg::COUNT_MAX : win);
			square_sum    = '0;
			sample_count  = '0;
			faults        = 0;
			samples_taken = 0;
			windows_full  = 0;
			windows_ended = 0;
		endfunction

		function logic [16:0] floor_root(longint unsigned v);
			logic [16:0]     r;
			longint unsigned t;
			r = '0;
			for (int b = 16; b >= 0; b--) begin
				t = longint'(r) | (longint'(1) << b);
				if (t * t <= v)
					r = t[16:0];
			end
			return r;
		endfunction

		function void take_sample(logic signed [wrm_pkg::SAMPLE_W-1:0] s, logic last);
			longint          v;
			longint unsigned mean;
			level_rec_t      rec;
			v = s;
			square_sum   = square_sum + wrm_pkg::SUM_W'(v * v);
			sample_count = sample_count + 1'b1;
			samples_taken++;
			if (!last && sample_count < eff_window)
				return;
			mean = longint'(square_sum) / longint'(sample_count);
			rec.rms_level    = wrm_pkg::LEVEL_W'(floor_root(mean));
			rec.window_count = sample_count;
			rec.block_done   = last;
			levels_due.insert(levels_due.size(), rec);
			if (last)
				windows_ended++;
			else
				windows_full++;
			square_sum   = '0;
			sample_count = '0;
		endfunction

		function void match_level(logic [wrm_pkg::LEVEL_W-1:0] lvl,
				logic [wrm_pkg::COUNT_W-1:0] cnt, logic done);
			level_rec_t rec;
			if (levels_due.size() == 0) begin
				faults++;
				$display("%0t: level with none due: rms_level %0d window_count %0d block_done %0b",
					$time, lvl, cnt, done);
				return;
			end
			rec = levels_due.pop_front();
			if (lvl !== rec.rms_level) begin
				faults++;
				$display("%0t: rms_level expected %0d actual %0d", $time, rec.rms_level, lvl);
			end
			if (cnt !== rec.window_count) begin
				faults++;
				$display("%0t: window_count expected %0d actual %0d", $time, rec.window_count, cnt);
			end
			if (done !== rec.block_done) begin
				faults++;
				$display("%0t: block_done expected %0b actual %0b", $time, rec.block_done, done);
			end
		endfunction

		function int pending();
			return levels_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wrm_in_if  samples ();
	wrm_out_if levels ();

	windowed_rms_meter_top #(
		.WINDOW(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.levels(levels)
	);

	rms_window_tracker book = new(WIN);
	bit                send_calm;
	bit                take_calm;
	int                idle_cycles;
	int                random_items;

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_wait(ref bit calm);
		if ($urandom_range(0, 47) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic signed [wrm_pkg::SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			1, 2: return wrm_pkg::SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			default: return wrm_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic send_sample(input logic signed [wrm_pkg::SAMPLE_W-1:0] s, input logic last);
		int gap;
		gap = draw_wait(send_calm);
		repeat (gap) begin
			@(negedge clk);
			samples.valid <= 1'b0;
		end
		@(negedge clk);
		samples.valid     <= 1'b1;
		samples.sample    <= s;
		samples.block_end <= last;
		do @(posedge clk); while (!samples.ready);
		book.take_sample(s, last);
	endtask

	task automatic send_block(input int len, input bit ended, input bit pinned);
		for (int i = 0; i < len; i++)
			send_sample(pinned ? MOST_NEG : draw_sample(), ended && i == len - 1);
	endtask

	task automatic take_levels();
		int gap;
		forever begin
			gap = draw_wait(take_calm);
			repeat (gap) begin
				@(negedge clk);
				levels.ready <= 1'b0;
			end
			@(negedge clk);
			levels.ready <= 1'b1;
			do @(posedge clk); while (!levels.valid);
			book.match_level(levels.rms_level, levels.window_count, levels.block_done);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (levels.valid && levels.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles, %0d levels still due",
					$time, idle_cycles, book.pending());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int len;
		samples.valid     = 1'b0;
		samples.sample    = '0;
		samples.block_end = 1'b0;
		levels.ready      = 1'b0;
		arst_n            = 1'b0;
		idle_cycles       = 0;
		random_items      = 0;
		send_calm         = 1'b0;
		take_calm         = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			take_levels();
		join_none

		send_sample(16'sd0, 1'b1);
		send_sample(MOST_POS, 1'b1);
		send_sample(MOST_NEG, 1'b1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd1, 1'b1);
		send_sample(16'sh5555, 1'b1);
		send_sample(16'shAAAA, 1'b1);
		send_sample(MOST_POS, 1'b0);
		send_sample(MOST_NEG, 1'b1);
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd200, 1'b0);
		send_sample(16'sd300, 1'b1);
		send_sample(MOST_NEG, 1'b0);
		send_sample(MOST_NEG, 1'b0);
		send_sample(MOST_NEG, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sd4, 1'b1);

		send_block(8, 1'b1, 1'b1);

		while (random_items < RAND_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
			if (len > RAND_ITEMS - random_items)
				len = RAND_ITEMS - random_items;
			send_block(len, $urandom_range(0, 15) != 0, 1'b0);
			random_items += len;
		end
		send_sample(draw_sample(), 1'b1);

		@(negedge clk);
		samples.valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Run covered %0d samples, %0d windows closed full and %0d closed by block end.",
			book.samples_taken, book.windows_full, book.windows_ended);
		$display("Directed extremes plus %0d random samples; %0d field mismatches.",
			random_items, book.faults);
		if (book.faults == 0 && book.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
